// ===== hdl/kts_pkg.sv =====
package kts_pkg;

    // Default stack depth and fixed field widths.
    localparam int DEPTH_DEFAULT = 16;
    localparam int CODE_W        = 16;
    localparam int URG_W         = 8;
    localparam int IN_DATA_W     = 56;
    localparam int IN_USER_W     = 3;
    localparam int OUT_DATA_W    = 16;
    localparam int OUT_PAD_W     = 4;

    // Operation selected by each input transfer.
    typedef enum logic [2:0] {
        MODE_PUSH    = 3'd0,
        MODE_POP     = 3'd1,
        MODE_DELETE  = 3'd2,
        MODE_REPLACE = 3'd3,
        MODE_COUNT   = 3'd4
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // One stack entry as held in the entry memory.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [URG_W-1:0]  urgency;
    } entry_t;

    // Count and fill level as reported in a result.
    typedef logic [4:0] level_t;

endpackage

// ===== hdl/kts_store.sv =====
module kts_store #(
    parameter int DEPTH = kts_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  kts_pkg::entry_t            wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output kts_pkg::entry_t            rdata
);

    kts_pkg::entry_t mem [DEPTH];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/keyed_task_stack_core.sv =====
// Keyed task stack: a bounded stack of entries, each a 16-bit code and an 8-bit urgency.
// Input channel (s_*): one transfer carries one operation, selected by s_tuser
// (push, pop, delete by code, replace by code, count urgent). Output channel (m_*):
// exactly one result transfer per input transfer, in order, carrying status,
// urgent count and the fill level after the operation.
// Push, pop and unknown operations pass from the input transfer through the done
// state to the output register. Delete, replace and count walk the entry memory
// from the top down, one read a cycle through its single registered read port;
// a delete below the top then moves each entry above the hit down one place, one
// entry a cycle. One operation is in flight at a time; s_tready is high only while
// the sequencer is idle.
// Reset clears the fill level, the sequencer and the output valid flag; the entry
// memory needs no clearing since only entries below the fill level are read.
// When the receiver stalls, the finished result waits in the output register and
// the next input may still be taken; its result waits until the register frees.
module keyed_task_stack_core #(
    parameter int DEPTH = kts_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // From bit 0: code[15:0], urgency[23:16], new_code[39:24], new_urgency[47:40],
    // threshold[55:48].
    input  logic [kts_pkg::IN_DATA_W-1:0]      s_tdata,
    // From bit 0: mode[2:0].
    input  logic [kts_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // From bit 0: status[1:0], urgent_count[6:2], fill_level[11:7], zero padding.
    output logic [kts_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    // Input field decode.
    kts_pkg::mode_t              in_mode;
    logic [kts_pkg::CODE_W-1:0]  in_code;
    logic [kts_pkg::URG_W-1:0]   in_urg;
    logic [kts_pkg::CODE_W-1:0]  in_ncode;
    logic [kts_pkg::URG_W-1:0]   in_nurg;
    logic [kts_pkg::URG_W-1:0]   in_thr;
    logic                        in_xfer;

    assign in_mode  = kts_pkg::mode_t'(s_tuser);
    assign in_code  = s_tdata[15:0];
    assign in_urg   = s_tdata[23:16];
    assign in_ncode = s_tdata[39:24];
    assign in_nurg  = s_tdata[47:40];
    assign in_thr   = s_tdata[55:48];
    assign in_xfer  = s_tvalid && s_tready;

    // Control state.
    kts_pkg::state_t   state_reg, state_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [FW-1:0]     count_reg, count_next;
    kts_pkg::status_t  status_reg, status_next;
    logic              iss_act_reg, iss_act_next;
    logic [AW-1:0]     iss_addr_reg, iss_addr_next;
    logic              chk_act_reg, chk_act_next;
    logic [AW-1:0]     chk_addr_reg, chk_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [kts_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Operation operands held for the whole operation.
    kts_pkg::mode_t              mode_reg;
    logic [kts_pkg::CODE_W-1:0]  key_reg;
    logic [kts_pkg::CODE_W-1:0]  ncode_reg;
    logic [kts_pkg::URG_W-1:0]   nurg_reg;
    logic [kts_pkg::URG_W-1:0]   thr_reg;

    // Entry memory port.
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    kts_pkg::entry_t   mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    kts_pkg::entry_t   mem_rdata;

    // Shared compare unit: key match while searching, urgency test while counting.
    logic              cmp_hit;
    logic [AW-1:0]     top_idx;
    logic [FW-1:0]     fill_dec;
    logic              iss_last;

    assign cmp_hit  = (mode_reg == kts_pkg::MODE_COUNT) ? (mem_rdata.urgency >= thr_reg)
                                                        : (mem_rdata.code == key_reg);
    assign fill_dec = fill_reg - FW'(1);
    assign top_idx  = AW'(fill_dec);
    assign iss_last = (FW'(iss_addr_reg) == fill_dec);

    kts_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kts_pkg::ST_IDLE;
            fill_reg      <= '0;
            count_reg     <= '0;
            status_reg    <= kts_pkg::STAT_OK;
            iss_act_reg   <= 1'b0;
            iss_addr_reg  <= '0;
            chk_act_reg   <= 1'b0;
            chk_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            iss_act_reg   <= iss_act_next;
            iss_addr_reg  <= iss_addr_next;
            chk_act_reg   <= chk_act_next;
            chk_addr_reg  <= chk_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (in_xfer)
        begin
            mode_reg  <= in_mode;
            key_reg   <= in_code;
            ncode_reg <= in_ncode;
            nurg_reg  <= in_nurg;
            thr_reg   <= in_thr;
        end
    end

    // Sequencer: next state, memory control and result formation.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        iss_act_next   = iss_act_reg;
        iss_addr_next  = iss_addr_reg;
        chk_act_next   = chk_act_reg;
        chk_addr_next  = chk_addr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = chk_addr_reg;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = iss_addr_reg;

        case (state_reg)
            kts_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    count_next  = '0;
                    status_next = kts_pkg::STAT_OK;
                    state_next  = kts_pkg::ST_DONE;
                    case (in_mode)
                        kts_pkg::MODE_PUSH:
                        begin
                            if (fill_reg == FW'(DEPTH))
                            begin
                                status_next = kts_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we            = 1'b1;
                                mem_waddr         = AW'(fill_reg);
                                mem_wdata.code    = in_code;
                                mem_wdata.urgency = in_urg;
                                fill_next         = fill_reg + FW'(1);
                            end
                        end
                        kts_pkg::MODE_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = kts_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                fill_next = fill_dec;
                            end
                        end
                        kts_pkg::MODE_DELETE, kts_pkg::MODE_REPLACE, kts_pkg::MODE_COUNT:
                        begin
                            if (fill_reg == '0)
                            begin
                                if (in_mode != kts_pkg::MODE_COUNT)
                                begin
                                    status_next = kts_pkg::STAT_MISSING;
                                end
                            end
                            else
                            begin
                                // Walk down from the top entry.
                                state_next    = kts_pkg::ST_SCAN;
                                iss_act_next  = 1'b1;
                                iss_addr_next = top_idx;
                                chk_act_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            status_next = kts_pkg::STAT_OK;
                        end
                    endcase
                end
            end

            kts_pkg::ST_SCAN:
            begin
                // Issue one read a cycle; check the previous read's data.
                mem_re        = iss_act_reg;
                mem_raddr     = iss_addr_reg;
                iss_act_next  = iss_act_reg && (iss_addr_reg != '0);
                iss_addr_next = iss_addr_reg - AW'(1);
                chk_act_next  = iss_act_reg;
                chk_addr_next = iss_addr_reg;
                if (chk_act_reg)
                begin
                    if (mode_reg == kts_pkg::MODE_COUNT)
                    begin
                        if (cmp_hit)
                        begin
                            count_next = count_reg + FW'(1);
                        end
                        if (chk_addr_reg == '0)
                        begin
                            state_next   = kts_pkg::ST_DONE;
                            iss_act_next = 1'b0;
                            chk_act_next = 1'b0;
                        end
                    end
                    else if (cmp_hit)
                    begin
                        iss_act_next = 1'b0;
                        chk_act_next = 1'b0;
                        if (mode_reg == kts_pkg::MODE_REPLACE)
                        begin
                            mem_we            = 1'b1;
                            mem_waddr         = chk_addr_reg;
                            mem_wdata.code    = ncode_reg;
                            mem_wdata.urgency = nurg_reg;
                            state_next        = kts_pkg::ST_DONE;
                        end
                        else if (chk_addr_reg == top_idx)
                        begin
                            fill_next  = fill_dec;
                            state_next = kts_pkg::ST_DONE;
                        end
                        else
                        begin
                            // Close the gap: move entries above the hit down.
                            state_next    = kts_pkg::ST_SHIFT;
                            iss_act_next  = 1'b1;
                            iss_addr_next = chk_addr_reg + AW'(1);
                        end
                    end
                    else if (chk_addr_reg == '0)
                    begin
                        status_next  = kts_pkg::STAT_MISSING;
                        state_next   = kts_pkg::ST_DONE;
                        iss_act_next = 1'b0;
                        chk_act_next = 1'b0;
                    end
                end
            end

            kts_pkg::ST_SHIFT:
            begin
                // Read entry n while writing entry n-1 read in the cycle before.
                mem_re        = iss_act_reg;
                mem_raddr     = iss_addr_reg;
                iss_act_next  = iss_act_reg && !iss_last;
                iss_addr_next = iss_addr_reg + AW'(1);
                chk_act_next  = iss_act_reg;
                chk_addr_next = iss_addr_reg - AW'(1);
                if (chk_act_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_addr_reg;
                    mem_wdata = mem_rdata;
                end
                if (!iss_act_reg && !chk_act_reg)
                begin
                    fill_next  = fill_dec;
                    state_next = kts_pkg::ST_DONE;
                end
            end

            kts_pkg::ST_DONE:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{kts_pkg::OUT_PAD_W{1'b0}},
                                      kts_pkg::level_t'(fill_reg),
                                      kts_pkg::level_t'(count_reg),
                                      status_reg};
                    state_next     = kts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = kts_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == kts_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
